### rtl/si_stc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// si_stc_pkg
// Shared types and constants of the section table collector.
// ----------------------------------------------------------------------------
package si_stc_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int COUNT_W   = 9;
    localparam int COMP_W    = 32;
    localparam int PARSED_W  = 8;

    localparam logic [PARSED_W-1:0] PARSED_NONE = 8'hff;

    typedef enum logic [1:0] {
        OP_SECTION       = 2'd0,
        OP_CLEAR_STATS   = 2'd1,
        OP_FORGET_PARSED = 2'd2,
        OP_UNDEFINED     = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_STORED      = 3'd0,
        ST_RESTARTED   = 3'd1,
        ST_NOT_CURRENT = 3'd2,
        ST_DUPLICATE   = 3'd3,
        ST_CMD_DONE    = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_VERSION = 1'd0,
        CFG_PARSE_ENABLE  = 1'd1
    } cfg_index_t;

endpackage

### rtl/si_section_table_collector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// si_section_table_collector_top
// Collects the sections of one table, flags completion and keeps interval stats.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one decoded section header or
//   command per word. Output channel (out_valid / out_stall) returns exactly
//   one result word per input word, in order.
//   Config channel (cfg_valid / cfg_ready) writes match_version (index 0) and
//   parse_enable (index 1); cfg_ready is always high. Write only while idle.
// Pipeline:
//   A word passes the input register, then the result register. One word per
//   cycle is sustained while the result is not stalled; the state update for
//   each word is done combinationally between the two registers.
// Reset:
//   Received map, count and all statistics clear, parsed version goes to
//   none, match_version = 1, parse_enable = 0. No clearing pass is needed.
// Stall:
//   A stalled result holds; the input register still takes one more word,
//   then in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module si_section_table_collector_top #(
    parameter int MAX_SECTIONS = 256,
    parameter int OFFSET_BITS  = 48
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [si_stc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                             cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       opcode,
    input  logic [7:0]                       tbl_id,
    input  logic [15:0]                      table_id_ext,
    input  logic [4:0]                       version,
    input  logic                             current_next,
    input  logic [7:0]                       sect_num,
    input  logic [7:0]                       last_sect_num,
    input  logic [OFFSET_BITS-1:0]           stream_offset,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       status,
    output logic                             complete,
    output logic                             parse_now,
    output logic [si_stc_pkg::COUNT_W-1:0]   sections_held,
    output logic [7:0]                       held_table_id,
    output logic [15:0]                      held_table_ext,
    output logic [4:0]                       held_version,
    output logic [OFFSET_BITS-1:0]           completion_interval,
    output logic [OFFSET_BITS-1:0]           peak_interval,
    output logic [si_stc_pkg::COMP_W-1:0]    max_interval_index,
    output logic [si_stc_pkg::COMP_W-1:0]    completion_number
);
    import si_stc_pkg::*;

    localparam int IDX_W = $clog2(MAX_SECTIONS);

    // configuration
    logic match_version_reg;
    logic parse_enable_reg;

    // input register
    logic                   in_valid_reg;
    logic [1:0]             op_reg;
    logic [7:0]             tid_reg;
    logic [15:0]            ext_reg;
    logic [4:0]             ver_reg;
    logic                   cni_reg;
    logic [7:0]             sn_reg;
    logic [7:0]             last_reg;
    logic [OFFSET_BITS-1:0] off_reg;

    // collector state
    logic [MAX_SECTIONS-1:0] map_reg, map_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [7:0]              table_id_reg, table_id_next;
    logic [15:0]             table_ext_reg, table_ext_next;
    logic [4:0]              version_reg, version_next;
    logic [PARSED_W-1:0]     parsed_reg, parsed_next;
    logic [OFFSET_BITS-1:0]  prev_off_reg, prev_off_next;
    logic                    have_prev_reg, have_prev_next;
    logic [OFFSET_BITS-1:0]  max_gap_reg, max_gap_next;
    logic [COMP_W-1:0]       max_idx_reg, max_idx_next;
    logic [COMP_W-1:0]       comps_reg, comps_next;

    // result register
    logic                   out_valid_reg;
    status_t                status_reg, status_next;
    logic                   complete_reg, complete_next;
    logic                   parse_reg, parse_next;
    logic [COUNT_W-1:0]     held_reg, held_next;
    logic [OFFSET_BITS-1:0] interval_reg, interval_next;
    logic [COMP_W-1:0]      number_reg;

    logic advance;
    logic in_take;
    logic in_range;
    logic hit;
    logic [IDX_W-1:0] sn_idx;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign sn_idx   = sn_reg[IDX_W-1:0];
    assign in_range = COUNT_W'(sn_reg) < COUNT_W'(MAX_SECTIONS);
    assign hit      = in_range && map_reg[sn_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_version_reg <= 1'b1;
            parse_enable_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MATCH_VERSION: match_version_reg <= cfg_data;
                CFG_PARSE_ENABLE:  parse_enable_reg  <= cfg_data;
                default:           match_version_reg <= match_version_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg   <= opcode;
            tid_reg  <= tbl_id;
            ext_reg  <= table_id_ext;
            ver_reg  <= version;
            cni_reg  <= current_next;
            sn_reg   <= sect_num;
            last_reg <= last_sect_num;
            off_reg  <= stream_offset;
        end
    end

    // one step of the collector
    always_comb
    begin
        logic [COUNT_W-1:0] cnt;
        logic               stored;
        logic               done;

        map_next       = map_reg;
        count_next     = count_reg;
        table_id_next  = table_id_reg;
        table_ext_next = table_ext_reg;
        version_next   = version_reg;
        parsed_next    = parsed_reg;
        prev_off_next  = prev_off_reg;
        have_prev_next = have_prev_reg;
        max_gap_next   = max_gap_reg;
        max_idx_next   = max_idx_reg;
        comps_next     = comps_reg;
        status_next    = ST_CMD_DONE;
        complete_next  = 1'b0;
        parse_next     = 1'b0;
        interval_next  = '0;
        cnt            = count_reg;
        stored         = 1'b0;
        done           = 1'b0;

        case (op_reg)
            OP_CLEAR_STATS:
            begin
                max_gap_next = '0;
                max_idx_next = '0;
            end
            OP_FORGET_PARSED:
            begin
                parsed_next = PARSED_NONE;
            end
            OP_SECTION:
            begin
                if (!cni_reg)
                begin
                    status_next = ST_NOT_CURRENT;
                end
                else if (!in_range || hit)
                begin
                    status_next = ST_DUPLICATE;
                end
                else
                begin
                    stored = 1'b1;
                    if (count_reg == '0)
                    begin
                        table_id_next  = tid_reg;
                        table_ext_next = ext_reg;
                        version_next   = ver_reg;
                        cnt            = COUNT_W'(1);
                        status_next    = ST_STORED;
                    end
                    else if (match_version_reg && ver_reg != version_reg)
                    begin
                        map_next       = '0;
                        table_id_next  = tid_reg;
                        table_ext_next = ext_reg;
                        version_next   = ver_reg;
                        cnt            = COUNT_W'(1);
                        status_next    = ST_RESTARTED;
                    end
                    else
                    begin
                        cnt         = count_reg + COUNT_W'(1);
                        status_next = ST_STORED;
                    end
                    map_next[sn_idx] = 1'b1;
                    done = cnt == COUNT_W'(last_reg) + COUNT_W'(1);
                end
            end
            default:
            begin
                status_next = ST_CMD_DONE;
            end
        endcase

        held_next  = cnt;
        count_next = cnt;

        if (stored && done)
        begin
            complete_next = 1'b1;
            if (have_prev_reg && off_reg >= prev_off_reg)
            begin
                interval_next = off_reg - prev_off_reg;
            end
            prev_off_next  = off_reg;
            have_prev_next = 1'b1;
            if (interval_next > max_gap_reg)
            begin
                max_gap_next = interval_next;
                max_idx_next = comps_reg;
            end
            comps_next = comps_reg + COMP_W'(1);
            if (parse_enable_reg && parsed_reg != PARSED_W'(ver_reg))
            begin
                parse_next  = 1'b1;
                parsed_next = PARSED_W'(ver_reg);
            end
            map_next   = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg       <= '0;
            count_reg     <= '0;
            table_id_reg  <= '0;
            table_ext_reg <= '0;
            version_reg   <= '0;
            parsed_reg    <= PARSED_NONE;
            prev_off_reg  <= '0;
            have_prev_reg <= 1'b0;
            max_gap_reg   <= '0;
            max_idx_reg   <= '0;
            comps_reg     <= '0;
        end
        else if (advance)
        begin
            map_reg       <= map_next;
            count_reg     <= count_next;
            table_id_reg  <= table_id_next;
            table_ext_reg <= table_ext_next;
            version_reg   <= version_next;
            parsed_reg    <= parsed_next;
            prev_off_reg  <= prev_off_next;
            have_prev_reg <= have_prev_next;
            max_gap_reg   <= max_gap_next;
            max_idx_reg   <= max_idx_next;
            comps_reg     <= comps_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg   <= status_next;
            complete_reg <= complete_next;
            parse_reg    <= parse_next;
            held_reg     <= held_next;
            interval_reg <= interval_next;
            number_reg   <= comps_reg;
        end
    end

    // held identity and peak statistics are the state after the step; completion_number is the count before it
    assign out_valid           = out_valid_reg;
    assign status              = status_reg;
    assign complete            = complete_reg;
    assign parse_now           = parse_reg;
    assign sections_held       = held_reg;
    assign held_table_id       = table_id_reg;
    assign held_table_ext      = table_ext_reg;
    assign held_version        = version_reg;
    assign completion_interval = interval_reg;
    assign peak_interval       = max_gap_reg;
    assign max_interval_index  = max_idx_reg;
    assign completion_number   = number_reg;

endmodule

### rtl/si_stc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// si_stc_checker
// Port-level checks on the result channel of the section table collector.
// ----------------------------------------------------------------------------
module si_stc_checker #(
    parameter int OFFSET_BITS = 48
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [2:0]                     status,
    input logic                           complete,
    input logic                           parse_now,
    input logic [si_stc_pkg::COUNT_W-1:0] sections_held,
    input logic [OFFSET_BITS-1:0]         completion_interval
);
    import si_stc_pkg::*;

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(complete))
        else $error("stalled result word changed");

    // only a stored section can complete a table
    a_done_stored: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && complete |-> (status == ST_STORED || status == ST_RESTARTED)
            && sections_held != '0)
        else $error("completion without a stored section");

    a_parse_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_now |-> complete)
        else $error("parse request without completion");

    a_interval_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !complete |-> completion_interval == '0)
        else $error("interval reported without completion");

endmodule

bind si_section_table_collector_top si_stc_checker #(
    .OFFSET_BITS(OFFSET_BITS)
) u_si_stc_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .status             (status),
    .complete           (complete),
    .parse_now          (parse_now),
    .sections_held      (sections_held),
    .completion_interval(completion_interval)
);

### tb/si_stc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// si_stc_tb_checker
// Watches the config, section and result channels of the section table
// collector, works out the result of every accepted word from its own copy
// of the collector state, and compares each accepted result with it, in
// order. Hands the mismatch count and the number of results still owed to
// the testbench top.
// ----------------------------------------------------------------------------
module si_stc_tb_checker
    import si_stc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [1:0]           opcode,
    input  logic [7:0]           tbl_id,
    input  logic [15:0]          table_id_ext,
    input  logic [4:0]           version,
    input  logic                 current_next,
    input  logic [7:0]           sect_num,
    input  logic [7:0]           last_sect_num,
    input  logic [47:0]          stream_offset,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [2:0]           status,
    input  logic                 complete,
    input  logic                 parse_now,
    input  logic [COUNT_W-1:0]   sections_held,
    input  logic [7:0]           held_table_id,
    input  logic [15:0]          held_table_ext,
    input  logic [4:0]           held_version,
    input  logic [47:0]          completion_interval,
    input  logic [47:0]          peak_interval,
    input  logic [COMP_W-1:0]    max_interval_index,
    input  logic [COMP_W-1:0]    completion_number,
    output int                   mismatches,
    output int                   words_pending
);

    localparam int MAP_DEPTH = 256;

    typedef struct {
        status_t           status;
        logic              complete;
        logic              parse_now;
        logic [COUNT_W-1:0] held;
        logic [7:0]        tid;
        logic [15:0]       ext;
        logic [4:0]        ver;
        logic [47:0]       interval;
        logic [47:0]       max_gap;
        logic [COMP_W-1:0] max_idx;
        logic [COMP_W-1:0] number;
    } table_result_t;

    // collector state as the block should hold it
    logic [MAP_DEPTH-1:0] rx_map;
    logic [COUNT_W-1:0]   sec_count;
    logic [7:0]           cur_tid;
    logic [15:0]          cur_ext;
    logic [4:0]           cur_ver;
    logic [PARSED_W-1:0]  parsed_ver;
    logic [47:0]          prev_off;
    logic                 have_prev;
    logic [47:0]          gap_max;
    logic [COMP_W-1:0]    gap_max_idx;
    logic [COMP_W-1:0]    done_count;
    logic                 match_ver;
    logic                 parse_en;

    table_result_t pending_results[$];

    function automatic table_result_t collect_word(
        input logic [1:0]  op,
        input logic [7:0]  tid,
        input logic [15:0] ext,
        input logic [4:0]  ver,
        input logic        cni,
        input logic [7:0]  sn,
        input logic [7:0]  last,
        input logic [47:0] off
    );
        table_result_t r;
        logic [47:0]   gap;
        r.status    = ST_CMD_DONE;
        r.complete  = 1'b0;
        r.parse_now = 1'b0;
        r.number    = done_count;
        gap         = '0;
        case (op)
            OP_CLEAR_STATS:
            begin
                gap_max     = '0;
                gap_max_idx = '0;
            end
            OP_FORGET_PARSED:
                parsed_ver = PARSED_NONE;
            OP_SECTION:
            begin
                if (!cni)
                    r.status = ST_NOT_CURRENT;
                else if (int'(sn) >= MAP_DEPTH || rx_map[sn])
                    r.status = ST_DUPLICATE;
                else
                begin
                    if (sec_count == '0)
                    begin
                        cur_tid   = tid;
                        cur_ext   = ext;
                        cur_ver   = ver;
                        sec_count = 9'd1;
                        r.status  = ST_STORED;
                    end
                    else if (match_ver && ver != cur_ver)
                    begin
                        rx_map    = '0;
                        cur_tid   = tid;
                        cur_ext   = ext;
                        cur_ver   = ver;
                        sec_count = 9'd1;
                        r.status  = ST_RESTARTED;
                    end
                    else
                    begin
                        sec_count = sec_count + 9'd1;
                        r.status  = ST_STORED;
                    end
                    rx_map[sn] = 1'b1;

                    if (sec_count == {1'b0, last} + 9'd1)
                    begin
                        r.complete = 1'b1;
                        if (have_prev && off >= prev_off)
                            gap = off - prev_off;
                        prev_off  = off;
                        have_prev = 1'b1;
                        if (gap > gap_max)
                        begin
                            gap_max     = gap;
                            gap_max_idx = done_count;
                        end
                        done_count = done_count + 1'b1;
                        // parsed version follows the completing section
                        if (parse_en && parsed_ver != {3'b000, ver})
                        begin
                            r.parse_now = 1'b1;
                            parsed_ver  = {3'b000, ver};
                        end
                    end
                end
            end
            default: ;
        endcase
        r.held     = sec_count;
        r.tid      = cur_tid;
        r.ext      = cur_ext;
        r.ver      = cur_ver;
        r.interval = gap;
        r.max_gap  = gap_max;
        r.max_idx  = gap_max_idx;
        if (r.complete)
        begin
            rx_map    = '0;
            sec_count = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        table_result_t want;
        if (!rst_n)
        begin
            rx_map      = '0;
            sec_count   = '0;
            cur_tid     = '0;
            cur_ext     = '0;
            cur_ver     = '0;
            parsed_ver  = PARSED_NONE;
            prev_off    = '0;
            have_prev   = 1'b0;
            gap_max     = '0;
            gap_max_idx = '0;
            done_count  = '0;
            match_ver   = 1'b1;
            parse_en    = 1'b0;
            pending_results.delete();
            mismatches    = 0;
            words_pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("complete", want.complete, complete);
                    check_field("parse_now", want.parse_now, parse_now);
                    check_field("sections_held", want.held, sections_held);
                    check_field("held_table_id", want.tid, held_table_id);
                    check_field("held_table_ext", want.ext, held_table_ext);
                    check_field("held_version", want.ver, held_version);
                    check_field("completion_interval", want.interval,
                                completion_interval);
                    check_field("peak_interval", want.max_gap, peak_interval);
                    check_field("max_interval_index", want.max_idx,
                                max_interval_index);
                    check_field("completion_number", want.number,
                                completion_number);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MATCH_VERSION: match_ver = cfg_data;
                    CFG_PARSE_ENABLE:  parse_en  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                pending_results.push_back(collect_word(opcode, tbl_id,
                    table_id_ext, version, current_next, sect_num,
                    last_sect_num, stream_offset));
            words_pending = pending_results.size();
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the section table collector with directed section and command words,
// then with mostly well-formed tables of random content mixed with stray,
// duplicate and not-current words, under several register settings and
// random idling on both channels. The checker beside the block predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import si_stc_pkg::*;

    localparam int OFF_W     = 48;
    localparam int LIMIT     = 500000;
    localparam int HOLD_LEN  = 400;
    localparam int DRAIN_LEN = 6;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic                 cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           opcode;
    logic [7:0]           tbl_id;
    logic [15:0]          table_id_ext;
    logic [4:0]           version;
    logic                 current_next;
    logic [7:0]           sect_num;
    logic [7:0]           last_sect_num;
    logic [OFF_W-1:0]     stream_offset;
    logic                 out_valid;
    logic                 out_stall;
    logic [2:0]           status;
    logic                 complete;
    logic                 parse_now;
    logic [COUNT_W-1:0]   sections_held;
    logic [7:0]           held_table_id;
    logic [15:0]          held_table_ext;
    logic [4:0]           held_version;
    logic [OFF_W-1:0]     completion_interval;
    logic [OFF_W-1:0]     peak_interval;
    logic [COMP_W-1:0]    max_interval_index;
    logic [COMP_W-1:0]    completion_number;

    int mismatches;
    int words_pending;

    int               cycle_count = 0;
    int               words_sent  = 0;
    bit               gap_free    = 1'b0;
    bit               hold_off    = 1'b0;
    logic [OFF_W-1:0] cur_off     = '0;
    logic [4:0]       prev_ver    = '0;

    si_section_table_collector_top uut (.*);

    si_stc_tb_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 50);
    endfunction

    function automatic logic [OFF_W-1:0] rand_off();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[OFF_W-1:0];
    endfunction

    // entered and left just after a rising edge
    task automatic send_word(input logic [1:0] op, input logic [7:0] tid,
                             input logic [15:0] ext, input logic [4:0] ver,
                             input logic cni, input logic [7:0] sn,
                             input logic [7:0] last, input logic [OFF_W-1:0] off);
        int gap;
        gap = gap_free ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        tbl_id        <= tid;
        table_id_ext  <= ext;
        version       <= ver;
        current_next  <= cni;
        sect_num      <= sn;
        last_sect_num <= last;
        stream_offset <= off;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_noise(input logic [1:0] op);
        send_word(op, 8'($urandom), 16'($urandom), 5'($urandom), 1'($urandom),
                  8'($urandom), 8'($urandom), rand_off());
    endtask

    task automatic send_section(input logic [7:0] tid, input logic [15:0] ext,
                                input logic [4:0] ver, input logic [7:0] sn,
                                input logic [7:0] last);
        if ($urandom_range(0, 49) == 0)
            cur_off = rand_off();
        else
            cur_off = cur_off + OFF_W'($urandom_range(1, 20000));
        send_word(OP_SECTION, tid, ext, ver, 1'b1, sn, last, cur_off);
    endtask

    // kind: 0 with stray words mixed in, 1 the same but abandoned part way, 2 clean
    task automatic send_table(input logic [7:0] last, input int kind);
        int         order[256];
        int         n;
        int         i;
        int         j;
        int         t;
        int         r;
        logic [7:0]  tid;
        logic [15:0] ext;
        logic [4:0]  ver;
        tid = 8'($urandom);
        ext = 16'($urandom);
        ver = ($urandom_range(0, 1) == 0) ? prev_ver : 5'($urandom);
        prev_ver = ver;
        n = int'(last) + 1;
        for (i = 0; i < n; i++)
            order[i] = i;
        for (i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        if (kind == 1)
            n = $urandom_range(1, n);
        for (i = 0; i < n; i++)
        begin
            r = (kind == 2) ? 99 : $urandom_range(0, 99);
            if (r < 5 && i > 0)
                // repeat of a held section, now and then under another version
                send_section(tid, ext, (r < 2) ? ver + 5'd1 : ver,
                             8'(order[$urandom_range(0, i - 1)]), last);
            else if (r < 9)
                send_word(OP_SECTION, tid, ext, ver, 1'b0, 8'(order[i]), last,
                          rand_off());
            else if (r < 11)
                send_noise(2'($urandom_range(1, 3)));
            else if (r < 13)
                send_section(tid, ext, ver ^ 5'($urandom_range(1, 31)),
                             8'(order[i]), last);
            send_section(tid, ext, ver, 8'(order[i]), last);
        end
    endtask

    task automatic random_phase(input int quota);
        int start;
        int r;
        start = words_sent;
        while (words_sent - start < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                send_table((r < 8) ? 8'($urandom_range(8, 40)) : 8'($urandom_range(0, 6)),
                           ($urandom_range(0, 9) == 0) ? 1 : 0);
            else
                send_noise(2'($urandom_range(0, 3)));
        end
    endtask

    // waits until every owed result is out and the pipeline is empty;
    // the first edge lets the checker count the last word sent
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (DRAIN_LEN) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_mode(input logic match, input logic parse);
        settle();
        write_reg(CFG_MATCH_VERSION, match);
        write_reg(CFG_PARSE_ENABLE, parse);
    endtask

    // receiver side: random stalls, clean stretches, one long hold on request
    initial
    begin : receiver
        int r;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off)
            begin
                hold_off = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    out_stall <= 1'b0;
                    repeat (60) @(posedge clk);
                end
                else if (r < 55)
                begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
                else
                begin
                    out_stall <= 1'b1;
                    repeat (pick_gap() + 1) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_MATCH_VERSION;
        cfg_data      = 1'b0;
        in_valid      = 1'b0;
        opcode        = OP_SECTION;
        tbl_id        = '0;
        table_id_ext  = '0;
        version       = '0;
        current_next  = 1'b0;
        sect_num      = '0;
        last_sect_num = '0;
        stream_offset = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset settings: matching on, parsing off
        send_word(OP_CLEAR_STATS, '0, '0, '0, 1'b1, '0, '0, '0);
        send_word(OP_FORGET_PARSED, '0, '0, '0, 1'b1, '0, '0, '0);
        send_word(OP_UNDEFINED, 8'hff, 16'hffff, 5'h1f, 1'b1, 8'hff, 8'hff, '1);
        send_word(OP_SECTION, 8'h02, 16'h0001, 5'd0, 1'b0, 8'd0, 8'd0, 48'd500);
        send_word(OP_SECTION, 8'h02, 16'h0001, 5'd0, 1'b1, 8'd0, 8'd0, 48'd1000);
        send_word(OP_SECTION, 8'h42, 16'h1234, 5'd2, 1'b1, 8'd1, 8'd1, 48'd3000);
        send_word(OP_SECTION, 8'h42, 16'h1234, 5'd7, 1'b1, 8'd1, 8'd1, 48'd3500);
        send_word(OP_SECTION, 8'h42, 16'h1234, 5'd2, 1'b1, 8'd0, 8'd1, 48'd6000);
        send_word(OP_SECTION, 8'h46, 16'h0100, 5'd3, 1'b1, 8'd0, 8'd2, 48'd7000);
        send_word(OP_SECTION, 8'h46, 16'h0100, 5'd4, 1'b1, 8'd1, 8'd2, 48'd8000);
        send_word(OP_SECTION, 8'h46, 16'h0100, 5'd4, 1'b1, 8'd0, 8'd2, 48'd9000);
        send_word(OP_SECTION, 8'h46, 16'h0100, 5'd4, 1'b1, 8'd2, 8'd2, 48'd9500);
        // offset going backwards
        send_word(OP_SECTION, 8'h00, 16'h0000, 5'd0, 1'b1, 8'd0, 8'd0, 48'd100);
        send_word(OP_SECTION, 8'hff, 16'hffff, 5'h1f, 1'b1, 8'hff, 8'd0, '1);
        send_word(OP_CLEAR_STATS, '0, '0, '0, 1'b1, '0, '0, '0);

        set_mode(1'b1, 1'b1);
        send_word(OP_SECTION, 8'h10, 16'h0010, 5'd5, 1'b1, 8'd0, 8'd0, 48'd200);
        send_word(OP_SECTION, 8'h10, 16'h0010, 5'd5, 1'b1, 8'd0, 8'd0, 48'd400);
        send_word(OP_FORGET_PARSED, '0, '0, '0, 1'b0, '0, '0, '0);
        send_word(OP_SECTION, 8'h10, 16'h0010, 5'd5, 1'b1, 8'd0, 8'd0, 48'd900);

        // without matching the first section fixes the held version
        set_mode(1'b0, 1'b1);
        send_word(OP_SECTION, 8'h50, 16'h0a0a, 5'd1, 1'b1, 8'd0, 8'd1, 48'd1200);
        send_word(OP_SECTION, 8'h51, 16'h0b0b, 5'd9, 1'b1, 8'd1, 8'd1, 48'd1300);

        set_mode(1'b0, 1'b0);
        send_word(OP_SECTION, '0, '0, '0, 1'b1, '0, '0, '0);

        // random part
        set_mode(1'b1, 1'b0);
        random_phase(120);
        send_table(8'd255, 2);
        hold_off = 1'b1;
        gap_free = 1'b1;
        send_table(8'd30, 2);
        gap_free = 1'b0;

        set_mode(1'b1, 1'b1);
        random_phase(120);
        set_mode(1'b0, 1'b1);
        random_phase(120);
        set_mode(1'b0, 1'b0);
        random_phase(100);
        set_mode(1'b1, 1'b1);
        gap_free = 1'b1;
        random_phase(60);
        gap_free = 1'b0;

        settle();
        repeat (DRAIN_LEN) @(posedge clk);
        if (mismatches == 0 && words_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### si_section_table_collector_top.f
rtl/si_stc_pkg.sv
rtl/si_section_table_collector_top.sv
rtl/si_stc_checker.sv
tb/si_stc_checker.sv
tb/tb_top.sv
